@@ design/sdb64_pkg.sv @@
// Shared types, constants and a helper function of the spectrum dB base64 encoder.
package sdb64_pkg;

   // Field and register widths.
   localparam int POWER_BITS      = 48;
   localparam int REQ_DATA_BITS   = ((POWER_BITS + 7) / 8) * 8;
   localparam int ACCUM_BITS      = 24;
   localparam int LENGTH_BITS     = 17;
   localparam int CSR_DATA_BITS   = 24;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CHAR_BITS       = 8;
   localparam int CODE_BITS       = 24;
   localparam int DIGIT_BITS      = 6;
   localparam int CHARS_PER_CODE  = CODE_BITS / DIGIT_BITS;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_ACCUMS      = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPECTRUM_LENGTH = 1'b1;

   // Reset values of the registers.
   localparam logic [ACCUM_BITS-1:0]  ACCUM_RESET  = ACCUM_BITS'(1);
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(32768);

   localparam int SKIP_BINS = 10;

   // Fixed-point log2 unit.
   localparam int LOG_FRAC_BITS = 24;
   localparam int DEN_BITS      = ACCUM_BITS + LENGTH_BITS + 1;
   localparam int LOG_IN_BITS   = (POWER_BITS > DEN_BITS) ? POWER_BITS : DEN_BITS;
   localparam int EXP_BITS      = $clog2(LOG_IN_BITS);
   localparam int LOG_BITS      = EXP_BITS + LOG_FRAC_BITS;
   localparam int MANT_BITS     = 32;
   localparam int NIBBLE_BITS   = 4;

   // dB arithmetic.
   localparam int DIFF_BITS  = LOG_BITS + 1;
   localparam int COEF_BITS  = 26;
   localparam int PROD_BITS  = DIFF_BITS + COEF_BITS;
   localparam int T_BITS     = PROD_BITS + 1;
   localparam int T_SHIFT    = LOG_FRAC_BITS + 6;
   localparam int Q_BITS     = T_BITS - T_SHIFT;

   localparam logic signed [DIFF_BITS-1:0] DIFF_LO =
      -DIFF_BITS'(64'd16 << LOG_FRAC_BITS);
   localparam logic signed [DIFF_BITS-1:0] DIFF_HI =
      DIFF_BITS'(64'd48 << LOG_FRAC_BITS);
   localparam logic signed [COEF_BITS-1:0] LOG10_2_Q6 = COEF_BITS'(19265920);
   localparam logic signed [T_BITS-1:0] DB_OFFSET_T =
      T_BITS'(64'd3830000 << T_SHIFT);
   localparam logic [CODE_BITS-1:0] CODE_MAX = CODE_BITS'(16700000);

   // Request to the log2 unit.
   typedef struct packed {
      logic                   start;
      logic [LOG_IN_BITS-1:0] value;
   } log_req_type;

   // Status of the log2 unit; done pulses for one cycle with the result.
   typedef struct packed {
      logic                done;
      logic [LOG_BITS-1:0] result;
   } log_stat_type;

   // One finished code handed to the character serializer.
   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 spectrum_end;
   } code_item_type;

   // Maps a six-bit value to its base64 character.
   function automatic logic [CHAR_BITS-1:0] b64_char(input logic [DIGIT_BITS-1:0] v);
      logic [CHAR_BITS-1:0] w;
      logic [CHAR_BITS-1:0] c;
      w = CHAR_BITS'(v);
      if (v < 6'd26) begin
         c = 8'd65 + w;
      end else if (v < 6'd52) begin
         c = 8'd71 + w;
      end else if (v < 6'd62) begin
         c = w - 8'd4;
      end else if (v == 6'd62) begin
         c = 8'd43;
      end else begin
         c = 8'd47;
      end
      return c;
   endfunction

endpackage

@@ design/sdb64_log2.sv @@
// Iterative fixed-point log2: nibble/bit normalizer, then one squaring step per fraction bit.
module sdb64_log2 (
   input  logic                  clock,
   input  logic                  reset,
   input  sdb64_pkg::log_req_type req,
   output sdb64_pkg::log_stat_type stat
);
   import sdb64_pkg::*;

   typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQUARE} lstate_type;

   localparam int STEP_BITS = $clog2(LOG_FRAC_BITS + 1);

   lstate_type                 state_ff, state_in;
   logic [STEP_BITS-1:0]       step_ff, step_in;
   logic                       done_ff, done_in;
   logic [LOG_IN_BITS-1:0]     norm_ff, norm_in;
   logic [EXP_BITS-1:0]        exp_ff, exp_in;
   logic [MANT_BITS-1:0]       mant_ff, mant_in;
   logic [LOG_FRAC_BITS-1:0]   frac_ff, frac_in;
   logic [2*MANT_BITS-1:0]     square;

   assign square = (2*MANT_BITS)'(mant_ff) * (2*MANT_BITS)'(mant_ff);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      norm_in  = norm_ff;
      exp_in   = exp_ff;
      mant_in  = mant_ff;
      frac_in  = frac_ff;
      case (state_ff)
         L_IDLE: begin
            if (req.start) begin
               norm_in  = req.value;
               exp_in   = EXP_BITS'(LOG_IN_BITS - 1);
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            // The value is never zero, so the search always ends.
            if (norm_ff[LOG_IN_BITS-1 -: NIBBLE_BITS] == '0) begin
               norm_in = norm_ff << NIBBLE_BITS;
               exp_in  = exp_ff - EXP_BITS'(NIBBLE_BITS);
            end else if (!norm_ff[LOG_IN_BITS-1]) begin
               norm_in = norm_ff << 1;
               exp_in  = exp_ff - EXP_BITS'(1);
            end else begin
               mant_in  = norm_ff[LOG_IN_BITS-1 -: MANT_BITS];
               step_in  = '0;
               state_in = L_SQUARE;
            end
         end
         L_SQUARE: begin
            // Squaring the mantissa doubles the log; a carry into bit 63 of the square is the next bit.
            frac_in = {frac_ff[LOG_FRAC_BITS-2:0], square[2*MANT_BITS-1]};
            if (square[2*MANT_BITS-1]) begin
               mant_in = square[2*MANT_BITS-1 -: MANT_BITS];
            end else begin
               mant_in = square[2*MANT_BITS-2 -: MANT_BITS];
            end
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_BITS'(LOG_FRAC_BITS - 1)) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      norm_ff <= norm_in;
      exp_ff  <= exp_in;
      mant_ff <= mant_in;
      frac_ff <= frac_in;
   end

   assign stat.done   = done_ff;
   assign stat.result = {exp_ff, frac_ff};

endmodule

@@ design/sdb64_emit.sv @@
// Character serializer: shifts a 24-bit code out six bits at a time as base64 characters.
module sdb64_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  sdb64_pkg::code_item_type          item,
   input  logic                              item_valid,
   output logic                              item_ready,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sdb64_pkg::CHAR_BITS-1:0]   rsp_tdata,  // [7:0] code_char
   output logic                              rsp_tlast,  // char_last
   output logic                              rsp_tuser   // [0] spectrum_end
);
   import sdb64_pkg::*;

   localparam int COUNT_BITS = $clog2(CHARS_PER_CODE);
   localparam logic [COUNT_BITS-1:0] LAST_CHAR = COUNT_BITS'(CHARS_PER_CODE - 1);

   logic                   busy_ff, busy_in;
   logic                   valid_ff, valid_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [CODE_BITS-1:0]   code_ff, code_in;
   logic                   end_ff, end_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   tlast_ff, tlast_in;
   logic                   tuser_ff, tuser_in;
   logic                   advance;

   assign advance = !valid_ff || rsp_tready;

   always_comb begin
      busy_in  = busy_ff;
      valid_in = valid_ff;
      count_in = count_ff;
      code_in  = code_ff;
      end_in   = end_ff;
      char_in  = char_ff;
      tlast_in = tlast_ff;
      tuser_in = tuser_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (busy_ff) begin
         if (advance) begin
            valid_in = 1'b1;
            char_in  = b64_char(code_ff[CODE_BITS-1 -: DIGIT_BITS]);
            tlast_in = (count_ff == LAST_CHAR);
            tuser_in = end_ff;
            code_in  = {code_ff[CODE_BITS-DIGIT_BITS-1:0], DIGIT_BITS'(0)};
            count_in = count_ff + COUNT_BITS'(1);
            if (count_ff == LAST_CHAR) begin
               busy_in = 1'b0;
            end
         end
      end else if (item_valid) begin
         busy_in  = 1'b1;
         code_in  = item.code;
         end_in   = item.spectrum_end;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      code_ff  <= code_in;
      end_ff   <= end_in;
      char_ff  <= char_in;
      tlast_ff <= tlast_in;
      tuser_ff <= tuser_in;
   end

   assign item_ready = !busy_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = char_ff;
   assign rsp_tlast  = tlast_ff;
   assign rsp_tuser  = tuser_ff;

endmodule

@@ design/spectrum_db_base64_encoder.sv @@
// Top level of the spectrum dB base64 encoder: bin counter, sequencer and dB arithmetic.
//
// Usage: each item on the req_ channel is one accumulated power bin (req_tdata[47:0]).
// For every bin the block sends four items on the rsp_ channel: base64 characters of
// the 24-bit dB code, most significant six bits first. rsp_tlast marks the fourth
// character and rsp_tuser is high on all four characters of the last bin of a spectrum.
// The csr_ channel writes num_accums (index 0) and spectrum_length (index 1); it is
// always ready and should be used only while the block is idle.
// A bin that is skipped or has zero power goes from the idle state straight to the
// handover state, where it waits until the serializer is free to take its code; the
// serializer then registers its first character. Other bins start the shared log2
// unit, which normalizes the value and then runs 24 squaring steps; the difference,
// multiply and sum states and the handover follow before the input is ready again,
// so a new bin is taken only after the previous one has been handed on. After a
// register write the first bin also runs log2 on 2*num_accums*spectrum_length first.
// The four characters leave at one per cycle while rsp_tready is high, and the next bin is worked on meanwhile.
// Reset clears the bin counter, loads num_accums = 1 and spectrum_length = 32768 and
// empties the output. A stall on rsp_ holds the current character; once the serializer
// is full the sequencer waits, and req_tready stays low until it can hand its code on.
module spectrum_db_base64_encoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [sdb64_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [47:0] power
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [sdb64_pkg::CHAR_BITS-1:0]     rsp_tdata,   // [7:0] code_char
   output logic                                rsp_tlast,   // char_last
   output logic                                rsp_tuser,   // [0] spectrum_end
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sdb64_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sdb64_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import sdb64_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DEN_LOG, S_PWR_LOG, S_DIFF, S_MUL, S_SUM, S_HAND
   } state_type;

   state_type                     state_ff, state_in;
   logic [ACCUM_BITS-1:0]         num_accums_ff, num_accums_in;
   logic [LENGTH_BITS-1:0]        spectrum_length_ff, spectrum_length_in;
   logic [LENGTH_BITS-1:0]        bin_index_ff, bin_index_in;
   logic                          den_log_valid_ff, den_log_valid_in;
   logic                          log_start_ff, log_start_in;

   logic [LOG_IN_BITS-1:0]        log_value_ff, log_value_in;
   logic [POWER_BITS-1:0]         power_ff, power_in;
   logic                          last_ff, last_in;
   logic [LOG_BITS-1:0]           den_log_ff, den_log_in;
   logic [LOG_BITS-1:0]           pwr_log_ff, pwr_log_in;
   logic signed [DIFF_BITS-1:0]   diff_ff, diff_in;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic [CODE_BITS-1:0]          k_ff, k_in;

   logic [ACCUM_BITS-1:0]         accums_eff;
   logic [LENGTH_BITS-1:0]        length_eff;
   logic [DEN_BITS-1:0]           den;
   logic                          accept;
   logic                          bin_last;
   logic                          bin_skip;
   logic signed [DIFF_BITS-1:0]   diff_raw;
   logic signed [T_BITS-1:0]      t_sum;
   logic [Q_BITS-1:0]             t_quot;

   log_req_type                   log_req;
   log_stat_type                  log_stat;
   code_item_type                 emit_item;
   logic                          emit_valid;
   logic                          emit_ready;

   assign accums_eff = (num_accums_ff == '0) ? ACCUM_BITS'(1) : num_accums_ff;
   assign length_eff = (spectrum_length_ff == '0) ? LENGTH_BITS'(1) : spectrum_length_ff;

   // Taken from the registers as they stand, so a bin right after a write sees the new values.
   assign den = {(DEN_BITS-1)'(accums_eff) * (DEN_BITS-1)'(length_eff), 1'b0};

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign bin_last = ({1'b0, bin_index_ff} + (LENGTH_BITS+1)'(1)) >= {1'b0, length_eff};
   assign bin_skip = bin_index_ff < LENGTH_BITS'(SKIP_BINS);

   assign diff_raw = $signed({1'b0, den_log_ff}) - $signed({1'b0, pwr_log_ff});
   assign t_sum    = DB_OFFSET_T + T_BITS'(prod_ff);
   assign t_quot   = t_sum[T_BITS-1:T_SHIFT];

   always_comb begin
      state_in           = state_ff;
      num_accums_in      = num_accums_ff;
      spectrum_length_in = spectrum_length_ff;
      bin_index_in       = bin_index_ff;
      den_log_valid_in   = den_log_valid_ff;
      log_start_in       = 1'b0;
      log_value_in       = log_value_ff;
      power_in           = power_ff;
      last_in            = last_ff;
      den_log_in         = den_log_ff;
      pwr_log_in         = pwr_log_ff;
      diff_in            = diff_ff;
      prod_in            = prod_ff;
      k_in               = k_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_ACCUMS:      num_accums_in = csr_data[ACCUM_BITS-1:0];
            CSR_SPECTRUM_LENGTH: spectrum_length_in = csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
         den_log_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               power_in     = req_tdata[POWER_BITS-1:0];
               last_in      = bin_last;
               bin_index_in = bin_last ? '0 : bin_index_ff + LENGTH_BITS'(1);
               if (bin_skip || req_tdata[POWER_BITS-1:0] == '0) begin
                  k_in     = CODE_MAX;
                  state_in = S_HAND;
               end else if (den_log_valid_ff) begin
                  log_start_in = 1'b1;
                  log_value_in = LOG_IN_BITS'(req_tdata[POWER_BITS-1:0]);
                  state_in     = S_PWR_LOG;
               end else begin
                  log_start_in = 1'b1;
                  log_value_in = LOG_IN_BITS'(den);
                  state_in     = S_DEN_LOG;
               end
            end
         end
         S_DEN_LOG: begin
            if (log_stat.done) begin
               den_log_in       = log_stat.result;
               den_log_valid_in = 1'b1;
               log_start_in     = 1'b1;
               log_value_in     = LOG_IN_BITS'(power_ff);
               state_in         = S_PWR_LOG;
            end
         end
         S_PWR_LOG: begin
            if (log_stat.done) begin
               pwr_log_in = log_stat.result;
               state_in   = S_DIFF;
            end
         end
         S_DIFF: begin
            if (diff_raw < DIFF_LO) begin
               diff_in = DIFF_LO;
            end else if (diff_raw > DIFF_HI) begin
               diff_in = DIFF_HI;
            end else begin
               diff_in = diff_raw;
            end
            state_in = S_MUL;
         end
         S_MUL: begin
            prod_in  = PROD_BITS'(diff_ff) * PROD_BITS'(LOG10_2_Q6);
            state_in = S_SUM;
         end
         S_SUM: begin
            // A non-positive sum gives code zero; large ones clamp to the top code.
            if (t_sum[T_BITS-1] || t_sum == '0) begin
               k_in = '0;
            end else if (t_quot > Q_BITS'(CODE_MAX)) begin
               k_in = CODE_MAX;
            end else begin
               k_in = t_quot[CODE_BITS-1:0];
            end
            state_in = S_HAND;
         end
         S_HAND: begin
            if (emit_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         num_accums_ff      <= ACCUM_RESET;
         spectrum_length_ff <= LENGTH_RESET;
         bin_index_ff       <= '0;
         den_log_valid_ff   <= 1'b0;
         log_start_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         num_accums_ff      <= num_accums_in;
         spectrum_length_ff <= spectrum_length_in;
         bin_index_ff       <= bin_index_in;
         den_log_valid_ff   <= den_log_valid_in;
         log_start_ff       <= log_start_in;
      end
   end

   always_ff @(posedge clock) begin
      log_value_ff <= log_value_in;
      power_ff     <= power_in;
      last_ff      <= last_in;
      den_log_ff   <= den_log_in;
      pwr_log_ff   <= pwr_log_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      k_ff         <= k_in;
   end

   assign log_req.start = log_start_ff;
   assign log_req.value = log_value_ff;

   sdb64_log2 u_log2 (
      .clock (clock),
      .reset (reset),
      .req   (log_req),
      .stat  (log_stat)
   );

   assign emit_valid             = (state_ff == S_HAND);
   assign emit_item.code         = k_ff;
   assign emit_item.spectrum_end = last_ff;

   sdb64_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item       (emit_item),
      .item_valid (emit_valid),
      .item_ready (emit_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // The log2 unit only finishes while the sequencer waits for it.
   a_log_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      log_stat.done |-> (state_ff == S_DEN_LOG || state_ff == S_PWR_LOG))
      else $error("log2 result arrived outside a log state");

   // A taken bin blocks the input until its code has been handed on.
   a_one_bin_at_a_time: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("input still ready after a bin was taken");

   // Codes handed to the serializer never exceed the top code.
   a_code_in_range: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> (k_ff <= CODE_MAX))
      else $error("dB code above its limit");

   // The power log only runs against a valid denominator log.
   a_den_log_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIFF) |-> den_log_valid_ff || $past(csr_valid))
      else $error("power log used without a denominator log");

endmodule

@@ tb/sv/tb_spectrum_db_base64_encoder.sv @@
// Self-checking testbench for the spectrum dB base64 encoder with its own dB code predictor.
`timescale 1ns / 1ps

module tb_spectrum_db_base64_encoder;
   import sdb64_pkg::*;

   localparam int CHOKE_CYCLES = 600;
   localparam logic signed [63:0] OFFSET_Q30 = 64'sd3830000 <<< (LOG_FRAC_BITS + 6);
   localparam logic signed [63:0] LOG10_2_SCALED = 64'sd19265920;
   localparam logic signed [63:0] DIFF_FLOOR = -(64'sd16 <<< LOG_FRAC_BITS);
   localparam logic signed [63:0] DIFF_CEIL = 64'sd48 <<< LOG_FRAC_BITS;

   typedef struct packed {
      logic [CHAR_BITS-1:0] code_char;
      logic                 char_last;
      logic                 spectrum_end;
   } b64_char_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [CHAR_BITS-1:0]      rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // Predictor state: registers and bin position as the block should hold them.
   logic [ACCUM_BITS-1:0]  accums_q = ACCUM_RESET;
   logic [LENGTH_BITS-1:0] length_q = LENGTH_RESET;
   logic [LENGTH_BITS-1:0] bin_pos = '0;

   b64_char_type     char_queue[$];
   logic [47:0]      power_queue[$];
   int               bins_queued = 0;
   int               bins_taken = 0;
   int               errors = 0;
   logic             req_taken = 1'b0;
   logic             rsp_taken = 1'b0;
   logic             csr_taken = 1'b0;
   logic             idle_on = 1'b1;
   int               chokes_asked = 0;
   int               chokes_done = 0;
   int               src_wait = 0;
   int               sink_wait = 0;

   spectrum_db_base64_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // Fixed-point log2 by repeated squaring of a 31-bit fraction mantissa.
   function automatic logic [63:0] log2_q(input logic [63:0] v);
      int unsigned e;
      logic [63:0] m;
      logic [63:0] frac;
      e = 63;
      while (e > 0 && !v[e]) e--;
      if (e >= 31) m = v >> (e - 31);
      else m = v << (31 - e);
      frac = '0;
      for (int i = 0; i < LOG_FRAC_BITS; i++) begin
         m = (m * m) >> 31;
         frac = frac << 1;
         if (m >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            m = m >> 1;
         end
      end
      return (64'(e) << LOG_FRAC_BITS) | frac;
   endfunction

   function automatic logic [CODE_BITS-1:0] db_code(input logic [47:0] power,
                                                    input logic [ACCUM_BITS-1:0] acc,
                                                    input logic [LENGTH_BITS-1:0] len);
      logic [63:0] den;
      logic signed [63:0] diff;
      logic signed [63:0] t;
      logic signed [63:0] k;
      if (power == '0) return CODE_MAX;
      den = 64'(acc) * 64'(len) * 64'd2;
      diff = $signed(log2_q(den)) - $signed(log2_q(64'(power)));
      if (diff < DIFF_FLOOR) diff = DIFF_FLOOR;
      if (diff > DIFF_CEIL) diff = DIFF_CEIL;
      t = OFFSET_Q30 + diff * LOG10_2_SCALED;
      if (t <= 0) return '0;
      k = t >>> (LOG_FRAC_BITS + 6);
      if (k > 64'(CODE_MAX)) k = 64'(CODE_MAX);
      return k[CODE_BITS-1:0];
   endfunction

   function automatic logic [CHAR_BITS-1:0] digit_char(input logic [DIGIT_BITS-1:0] d);
      int unsigned n;
      n = d;
      if (n <= 25) return CHAR_BITS'(65 + n);        // A-Z
      else if (n <= 51) return CHAR_BITS'(97 + n - 26);  // a-z
      else if (n <= 61) return CHAR_BITS'(48 + n - 52);  // 0-9
      else if (n == 62) return CHAR_BITS'(43);
      else return CHAR_BITS'(47);
   endfunction

   // Works out the four characters of one bin and advances the bin position.
   task automatic predict_bin(input logic [47:0] power);
      logic [ACCUM_BITS-1:0]  acc;
      logic [LENGTH_BITS-1:0] len;
      logic [CODE_BITS-1:0]   code;
      logic                   last;
      b64_char_type           c;
      acc = (accums_q == '0) ? ACCUM_BITS'(1) : accums_q;
      len = (length_q == '0) ? LENGTH_BITS'(1) : length_q;
      code = (bin_pos < SKIP_BINS) ? CODE_MAX : db_code(power, acc, len);
      last = (18'(bin_pos) + 18'd1 >= 18'(len));
      for (int j = 0; j < CHARS_PER_CODE; j++) begin
         c.code_char = digit_char(code[CODE_BITS-1-DIGIT_BITS*j -: DIGIT_BITS]);
         c.char_last = (j == CHARS_PER_CODE - 1);
         c.spectrum_end = last;
         char_queue.push_back(c);
      end
      bin_pos = last ? '0 : bin_pos + 1'b1;
   endtask

   // Spreads the power over all magnitudes so that every bit length is reached.
   function automatic logic [47:0] draw_power();
      int unsigned nbits;
      logic [47:0] v;
      nbits = $urandom_range(48, 0);
      v = 48'({$urandom, $urandom});
      if (nbits == 0) return '0;
      if (nbits < 48) v = v & ((48'd1 << nbits) - 48'd1);
      v[nbits-1] = 1'b1;
      return v;
   endfunction

   // Monitor: handshakes, prediction and comparison at the rising edge.
   always @(posedge clock) begin
      b64_char_type want;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      csr_taken <= !reset && csr_valid && csr_ready;
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_NUM_ACCUMS) accums_q = csr_data[ACCUM_BITS-1:0];
         else if (csr_index == CSR_SPECTRUM_LENGTH) length_q = csr_data[LENGTH_BITS-1:0];
      end
      if (!reset && req_tvalid && req_tready) begin
         predict_bin(req_tdata[47:0]);
         bins_taken++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (char_queue.size() == 0) begin
            $error("unexpected item: code_char %0h char_last %0b spectrum_end %0b",
                   rsp_tdata, rsp_tlast, rsp_tuser);
            errors++;
         end else begin
            want = char_queue.pop_front();
            if (rsp_tdata !== want.code_char) begin
               $error("code_char: expected %0h, actual %0h", want.code_char, rsp_tdata);
               errors++;
            end
            if (rsp_tlast !== want.char_last) begin
               $error("char_last: expected %0b, actual %0b", want.char_last, rsp_tlast);
               errors++;
            end
            if (rsp_tuser !== want.spectrum_end) begin
               $error("spectrum_end: expected %0b, actual %0b", want.spectrum_end, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // Bin driver: one item from the pending queue, then a random gap while idling is on.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait <= 0;
      end else if (!req_tvalid || req_taken) begin
         if (src_wait != 0) begin
            req_tvalid <= 1'b0;
            src_wait <= src_wait - 1;
         end else if (power_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= REQ_DATA_BITS'(power_queue.pop_front());
            src_wait <= idle_on ? int'($urandom_range(15, 0)) : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Character sink: random stall after each item while idling is on, and a long hold-off on request.
   always @(negedge clock) begin
      int hold;
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_wait <= 0;
      end else begin
         hold = sink_wait;
         if (chokes_done != chokes_asked) begin
            hold = CHOKE_CYCLES;
            chokes_done <= chokes_done + 1;
         end else if (rsp_taken) begin
            hold = idle_on ? int'($urandom_range(15, 0)) : 0;
         end else if (hold != 0) begin
            hold = hold - 1;
         end
         sink_wait <= hold;
         rsp_tready <= (hold == 0);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      while (!csr_taken) @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Waits until every bin is taken and every character has come back.
   task automatic drain();
      @(negedge clock);
      while (bins_taken != bins_queued || char_queue.size() != 0) @(negedge clock);
   endtask

   // Returns at a rising edge with the block idle, ready for register writes.
   task automatic settle();
      drain();
      repeat (8) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic queue_power(input logic [47:0] p);
      power_queue.push_back(p);
      bins_queued++;
   endtask

   task automatic queue_random(input int n);
      @(posedge clock);
      repeat (n) queue_power(draw_power());
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: the first ten bins are skipped, then magnitude extremes.
      repeat (SKIP_BINS) queue_power(draw_power());
      queue_power(48'h0);
      queue_power(48'h1);
      queue_power(48'h2);
      queue_power(48'hFFFF_FFFF_FFFF);
      queue_power(48'h8000_0000_0000);
      queue_power(48'h5555_5555_5555);
      queue_power(48'hAAAA_AAAA_AAAA);
      queue_power(48'h0000_0001_0000);
      settle();

      // Zero registers act as one: every bin ends its spectrum.
      write_csr(CSR_NUM_ACCUMS, '0);
      write_csr(CSR_SPECTRUM_LENGTH, '0);
      @(posedge clock);
      queue_power(48'h0);
      queue_power(48'hFFFF_FFFF_FFFF);
      queue_power(48'h1234_5678_9ABC);
      settle();

      // Largest registers; the length field keeps the low bits of the data.
      write_csr(CSR_NUM_ACCUMS, 24'hFF_FFFF);
      write_csr(CSR_SPECTRUM_LENGTH, 24'hFF_FFFF);
      queue_random(50);
      settle();

      // Short spectra without any idling; the bin position starts past the end.
      idle_on = 1'b0;
      write_csr(CSR_NUM_ACCUMS, CSR_DATA_BITS'($urandom_range(24'hFF_FFFF, 1)));
      write_csr(CSR_SPECTRUM_LENGTH, 24'd13);
      queue_random(60);
      settle();

      // Long sink hold-off while bins keep coming, so the input stalls.
      idle_on = 1'b1;
      write_csr(CSR_NUM_ACCUMS, 24'd1);
      write_csr(CSR_SPECTRUM_LENGTH, 24'd65536);
      queue_random(40);
      chokes_asked = chokes_asked + 1;
      settle();

      // The sender pauses halfway until every character is back.
      write_csr(CSR_NUM_ACCUMS, CSR_DATA_BITS'($urandom_range(4096, 1)));
      write_csr(CSR_SPECTRUM_LENGTH, 24'd25);
      queue_random(40);
      drain();
      queue_random(40);
      settle();

      write_csr(CSR_NUM_ACCUMS, CSR_DATA_BITS'($urandom_range(1000, 1)));
      write_csr(CSR_SPECTRUM_LENGTH, CSR_DATA_BITS'($urandom_range(40, 11)));
      queue_random(80);

      drain();
      repeat (60) @(negedge clock);
      if (char_queue.size() != 0) begin
         $error("%0d expected items never arrived", char_queue.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ spectrum_db_base64_encoder.f @@
design/sdb64_pkg.sv
design/sdb64_log2.sv
design/sdb64_emit.sv
design/spectrum_db_base64_encoder.sv
tb/sv/tb_spectrum_db_base64_encoder.sv
